FILE: sv/rcd_pkg.sv
// Shared types and constants for the grid raycaster.
// Used by the divider unit and by the top level; no dependencies.
package rcd_pkg;

  // Configuration port layout and register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H = 3'd7;

  // Request opcodes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  // Ray components are signed Q2.14 widened by the plane term.
  localparam int RAY_W  = 28;
  localparam int ARAY_W = 27;
  // Widest divisor: a ray magnitude or the wall span.
  localparam int DIV_DW = 27;
  // Wall span width (height times 2^16 over the distance).
  localparam int SPAN_W = 27;

  // Saturation limits of the result fields.
  localparam logic [23:0] DIST_MAX  = 24'hFFFFFF;
  localparam logic [21:0] STEP_MAX  = 22'h3FFFFF;
  localparam logic [20:0] START_MAX = 21'h1FFFFF;
  localparam logic [4:0]  SHADE_MOD = 5'd23;

  // Status of the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
    logic rem_nz;
  } div_stat_t;

  // Shade from the integer part of the distance: (23 - v mod 23) / 2.
  // The quotient by 23 uses 713 / 2^14, which is exact for 8-bit values.
  function automatic logic [3:0] shade_of(input logic [7:0] v);
    logic [17:0] m;
    logic [3:0]  q;
    logic [8:0]  qm;
    logic [4:0]  r;
    logic [4:0]  d;
    m  = {10'd0, v} * 18'd713;
    q  = m[17:14];
    qm = {5'd0, q} * 9'd23;
    r  = 5'({1'b0, v} - qm);
    d  = SHADE_MOD - r;
    return d[4:1];
  endfunction

endpackage

FILE: sv/raycast_column_dda.sv
// Grid raycaster top level: camera registers, map store, walk sequencer.
// Depends on rcd_pkg, rcd_ram (map cells) and rcd_div (shared divider).
//
// Usage: a request on the in_ channel either writes one map cell (op 0) or
// casts one screen column (op 1). A write gives no result. A cast gives
// exactly one result on the out_ channel.
// A cast runs the ray setup, the grid walk and the wall math in sequence,
// one request at a time. A cast uses up to five passes of the shared
// divider (two for the ray, distance, span, texture step); the walk makes
// one grid step and one map read a cycle, up to 2*MAP_DIM steps.
// The next request is taken as soon as the result sits in the output
// register, even while the receiver still stalls it; out_ holds its payload
// while stalled.
// Reset loads the default camera and runs a clearing pass over the map that
// writes one cell a cycle, all MAP_DIM*MAP_DIM cells (1024 by default); no
// request is taken during it, configuration writes are.
module raycast_column_dda import rcd_pkg::*; #(
  parameter int MAP_DIM  = 32,
  parameter int TEX_SIZE = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_op,
  input  logic [9:0]            in_column,
  input  logic [4:0]            in_cell_x,
  input  logic [4:0]            in_cell_y,
  input  logic [3:0]            in_cell_value,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [9:0]            out_column_out,
  output logic                  out_hit,
  output logic                  out_side,
  output logic [23:0]           out_wall_distance,
  output logic [9:0]            out_draw_start,
  output logic [9:0]            out_draw_end,
  output logic [4:0]            out_tex_column,
  output logic [21:0]           out_tex_step,
  output logic signed [21:0]    out_tex_start,
  output logic [3:0]            out_shade
);

  localparam int CW    = $clog2(MAP_DIM);
  localparam int DEPTH = MAP_DIM * MAP_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int STEPS = 2 * MAP_DIM;
  localparam int SCW   = $clog2(STEPS + 1);
  localparam int AXW   = 17 + $clog2(STEPS + 1);
  localparam int PW    = AXW + ARAY_W;
  localparam int MW    = $clog2(STEPS + 32) + 1;
  localparam int NW    = AXW + 14;
  localparam int TMW   = 23;

  typedef enum logic [4:0] {
    S_IDLE, S_MUL, S_DX_GO, S_DX_WT, S_DY_GO, S_DY_WT, S_INIT, S_PROD, S_WALK,
    S_DD_GO, S_DD_WT, S_DL_GO, S_DL_WT, S_DS_GO, S_DS_WT, S_FIN1, S_FIN2, S_OUT
  } state_t;

  state_t state_r;

  // Camera registers
  logic [20:0]        pos_x_r, pos_y_r;
  logic signed [15:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;
  logic [10:0]        scr_w_r, scr_h_r;

  // Map clearing pass
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  // Cast working registers
  logic [9:0]              col_r;
  logic signed [RAY_W-1:0] prodx_r, prody_r, rx_r, ry_r;
  logic [ARAY_W-1:0]       arx_r, ary_r;
  logic [AXW-1:0]          ax_r, ay_r, lasta_r;
  logic [PW-1:0]           px_r, py_r;
  logic signed [MW-1:0]    mx_r, my_r;
  logic                    side_r, offmap_r, pend_r, hit_r;
  logic [SCW-1:0]          stepc_r;
  logic [23:0]             d_r;
  logic [SPAN_W-1:0]       l_r;
  logic [21:0]             step_r;
  logic [9:0]              ds_r, de_r;
  logic [25:0]             off_r;
  logic [29:0]             wlo_r;
  logic [47:0]             tsprod_r;
  logic [4:0]              tcol_r;

  // Output register
  logic               out_valid_r;
  logic [9:0]         out_col_r;
  logic               out_hit_r, out_side_r;
  logic [23:0]        out_dist_r;
  logic [9:0]         out_ds_r, out_de_r;
  logic [4:0]         out_tcol_r;
  logic [21:0]        out_step_r;
  logic signed [21:0] out_ts_r;
  logic [3:0]         out_shade_r;

  // Combinational signals
  logic                    in_acc, cell_ok;
  logic [10:0]             weff, heff;
  logic signed [11:0]      sval;
  logic signed [RAY_W-1:0] mulx, muly, prod_sel, fq, ray_new;
  logic [RAY_W-1:0]        prod_mag;
  logic signed [15:0]      dir_sel;
  logic                    div_start;
  logic [NW-1:0]           div_num, div_quo;
  logic [DIV_DW-1:0]       div_den, dist_den;
  div_stat_t               div_stat;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr, ram_raddr, in_addr;
  logic [3:0]              ram_wdata, ram_rdata;
  logic                    stepx, offmap_n, walk_hit, walk_end;
  logic signed [MW-1:0]    dmx, dmy, mx_n, my_n;
  logic                    rxneg, ryneg;
  logic [9:0]              hh;
  logic [25:0]             lh;
  logic [26:0]             span_sum;
  logic [10:0]             hm2;
  logic signed [RAY_W-1:0] rsel;
  logic signed [52:0]      wmul;
  logic [15:0]             wfrac;
  logic [TMW-1:0]          tm;
  logic [6:0]              t7;
  logic                    mirror;

  // Request handshake: requests wait during clearing and while a cast runs.
  assign in_stall = clr_busy_r || (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Map write address; writes outside the map are dropped.
  assign cell_ok = ({2'b00, in_cell_x} < 7'(MAP_DIM)) && ({2'b00, in_cell_y} < 7'(MAP_DIM));
  assign in_addr = AW'(in_cell_x) * AW'(MAP_DIM) + AW'(in_cell_y);

  assign ram_we    = clr_busy_r || (in_acc && (in_op == OP_WRITE) && cell_ok);
  assign ram_waddr = clr_busy_r ? clr_addr_r : in_addr;
  assign ram_wdata = clr_busy_r ? 4'd0 : in_cell_value;

  // Effective screen sizes.
  assign weff = (scr_w_r == 11'd0) ? 11'd1 : scr_w_r;
  always_comb begin
    priority if (scr_h_r < 11'd4) begin
      heff = 11'd4;
    end else if (scr_h_r > 11'd1024) begin
      heff = 11'd1024;
    end else begin
      heff = scr_h_r;
    end
  end

  // Camera-x numerator: plane * (2*column - W).
  assign sval = $signed({1'b0, col_r, 1'b0}) - $signed({1'b0, weff});
  assign mulx = RAY_W'(plane_x_r) * RAY_W'(sval);
  assign muly = RAY_W'(plane_y_r) * RAY_W'(sval);

  // Floor division result folded into the ray component.
  assign prod_sel = (state_r == S_DY_GO || state_r == S_DY_WT) ? prody_r : prodx_r;
  assign dir_sel  = (state_r == S_DY_GO || state_r == S_DY_WT) ? dir_y_r : dir_x_r;
  assign prod_mag = prod_sel[RAY_W-1] ? RAY_W'(-prod_sel) : RAY_W'(prod_sel);
  always_comb begin
    if (prod_sel[RAY_W-1]) begin
      fq = -$signed(RAY_W'(div_quo)) - (div_stat.rem_nz ? RAY_W'(1) : RAY_W'(0));
    end else begin
      fq = $signed(RAY_W'(div_quo));
    end
  end
  assign ray_new = RAY_W'(dir_sel) + fq;

  // Divider operand selection by sequencer state.
  assign dist_den = side_r ? ary_r : arx_r;
  always_comb begin
    div_num   = '0;
    div_den   = '0;
    div_start = 1'b0;
    unique case (state_r)
      S_DX_GO, S_DY_GO: begin
        div_num   = NW'(prod_mag);
        div_den   = DIV_DW'(weff);
        div_start = 1'b1;
      end
      S_DD_GO: begin
        div_num   = {lasta_r, 14'd0};
        div_den   = dist_den;
        div_start = dist_den != '0;
      end
      S_DL_GO: begin
        div_num   = NW'({heff, 16'd0});
        div_den   = (d_r == 24'd0) ? DIV_DW'(1) : DIV_DW'(d_r);
        div_start = 1'b1;
      end
      S_DS_GO: begin
        div_num   = NW'(TEX_SIZE * 65536);
        div_den   = l_r;
        div_start = l_r != '0;
      end
      default: begin
        div_num   = '0;
        div_den   = '0;
        div_start = 1'b0;
      end
    endcase
  end

  rcd_div #(
    .NW (NW),
    .DW (DIV_DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  // Grid walk: choose the axis, advance the cell and issue its map read.
  assign rxneg    = rx_r[RAY_W-1];
  assign ryneg    = ry_r[RAY_W-1];
  assign stepx    = px_r < py_r;
  assign dmx      = rxneg ? '1 : MW'(1);
  assign dmy      = ryneg ? '1 : MW'(1);
  assign mx_n     = stepx ? mx_r + dmx : mx_r;
  assign my_n     = stepx ? my_r : my_r + dmy;
  assign offmap_n = mx_n[MW-1] || my_n[MW-1] || (mx_n >= $signed(MW'(MAP_DIM))) ||
                    (my_n >= $signed(MW'(MAP_DIM)));
  assign ram_raddr = AW'(mx_n[CW-1:0]) * AW'(MAP_DIM) + AW'(my_n[CW-1:0]);
  assign walk_hit  = pend_r && (offmap_r || (ram_rdata != 4'd0));
  assign walk_end  = pend_r && (stepc_r == SCW'(STEPS));

  rcd_ram #(
    .WIDTH (4),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Wall span and texture math.
  assign hh       = heff[10:1];
  assign lh       = l_r[SPAN_W-1:1];
  assign span_sum = {1'b0, lh} + 27'(hh);
  assign hm2      = heff - 11'd2;
  assign rsel     = side_r ? rx_r : ry_r;
  assign wmul     = 53'($signed({1'b0, d_r})) * 53'(rsel);
  assign wfrac    = (side_r ? pos_x_r[15:0] : pos_y_r[15:0]) + wlo_r[29:14];
  assign tm       = TMW'(wfrac) * TMW'(TEX_SIZE);
  assign t7       = tm[TMW-1:16];
  assign mirror   = (!side_r && !rxneg && (rx_r != '0)) || (side_r && ryneg);

  // Sequencer, configuration and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      pos_x_r     <= 21'd1441792;
      pos_y_r     <= 21'd786432;
      dir_x_r     <= -16'sd16384;
      dir_y_r     <= 16'sd0;
      plane_x_r   <= 16'sd0;
      plane_y_r   <= 16'sd10813;
      scr_w_r     <= 11'd160;
      scr_h_r     <= 11'd96;
    end else begin
      // Clearing pass after reset.
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end

      // Configuration writes.
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_POS_X:    pos_x_r   <= cfg_data;
          CFG_POS_Y:    pos_y_r   <= cfg_data;
          CFG_DIR_X:    dir_x_r   <= cfg_data[15:0];
          CFG_DIR_Y:    dir_y_r   <= cfg_data[15:0];
          CFG_PLANE_X:  plane_x_r <= cfg_data[15:0];
          CFG_PLANE_Y:  plane_y_r <= cfg_data[15:0];
          CFG_SCREEN_W: scr_w_r   <= cfg_data[10:0];
          CFG_SCREEN_H: scr_h_r   <= cfg_data[10:0];
        endcase
      end

      // The receiver took the result and no new one replaces it.
      if (out_valid_r && !out_stall && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc && (in_op == OP_CAST)) begin
            col_r   <= in_column;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prodx_r <= mulx;
          prody_r <= muly;
          state_r <= S_DX_GO;
        end
        S_DX_GO: state_r <= S_DX_WT;
        S_DX_WT: begin
          if (div_stat.done) begin
            rx_r    <= ray_new;
            state_r <= S_DY_GO;
          end
        end
        S_DY_GO: state_r <= S_DY_WT;
        S_DY_WT: begin
          if (div_stat.done) begin
            ry_r    <= ray_new;
            state_r <= S_INIT;
          end
        end
        S_INIT: begin
          arx_r   <= rxneg ? ARAY_W'(-rx_r) : ARAY_W'(rx_r);
          ary_r   <= ryneg ? ARAY_W'(-ry_r) : ARAY_W'(ry_r);
          ax_r    <= rxneg ? AXW'(pos_x_r[15:0]) : AXW'(17'h10000 - {1'b0, pos_x_r[15:0]});
          ay_r    <= ryneg ? AXW'(pos_y_r[15:0]) : AXW'(17'h10000 - {1'b0, pos_y_r[15:0]});
          mx_r    <= $signed(MW'(pos_x_r[20:16]));
          my_r    <= $signed(MW'(pos_y_r[20:16]));
          pend_r  <= 1'b0;
          stepc_r <= '0;
          state_r <= S_PROD;
        end
        S_PROD: begin
          px_r    <= PW'(ax_r) * PW'(ary_r);
          py_r    <= PW'(ay_r) * PW'(arx_r);
          state_r <= S_WALK;
        end
        S_WALK: begin
          priority if (walk_hit) begin
            hit_r   <= 1'b1;
            state_r <= S_DD_GO;
          end else if (walk_end) begin
            hit_r   <= 1'b0;
            state_r <= S_OUT;
          end else begin
            if (stepx) begin
              lasta_r <= ax_r;
              ax_r    <= ax_r + AXW'(65536);
              px_r    <= px_r + (PW'(ary_r) << 16);
              side_r  <= 1'b0;
            end else begin
              lasta_r <= ay_r;
              ay_r    <= ay_r + AXW'(65536);
              py_r    <= py_r + (PW'(arx_r) << 16);
              side_r  <= 1'b1;
            end
            mx_r     <= mx_n;
            my_r     <= my_n;
            offmap_r <= offmap_n;
            pend_r   <= 1'b1;
            stepc_r  <= stepc_r + 1'b1;
          end
        end
        S_DD_GO: begin
          if (dist_den == '0) begin
            d_r     <= DIST_MAX;
            state_r <= S_DL_GO;
          end else begin
            state_r <= S_DD_WT;
          end
        end
        S_DD_WT: begin
          if (div_stat.done) begin
            d_r     <= (div_quo > NW'(DIST_MAX)) ? DIST_MAX : div_quo[23:0];
            state_r <= S_DL_GO;
          end
        end
        S_DL_GO: state_r <= S_DL_WT;
        S_DL_WT: begin
          if (div_stat.done) begin
            l_r     <= {div_quo[SPAN_W-1:1], 1'b0};
            state_r <= S_DS_GO;
          end
        end
        S_DS_GO: begin
          if (l_r == '0) begin
            step_r  <= STEP_MAX;
            state_r <= S_FIN1;
          end else begin
            state_r <= S_DS_WT;
          end
        end
        S_DS_WT: begin
          if (div_stat.done) begin
            step_r  <= (div_quo > NW'(STEP_MAX)) ? STEP_MAX : div_quo[21:0];
            state_r <= S_FIN1;
          end
        end
        S_FIN1: begin
          if (lh >= 26'(hh)) begin
            ds_r  <= 10'd1;
            off_r <= lh - 26'(hh) + 26'd1;
          end else begin
            ds_r  <= 10'(26'(hh) - lh);
            off_r <= '0;
          end
          de_r    <= (span_sum > 27'(hm2)) ? hm2[9:0] : span_sum[9:0];
          wlo_r   <= wmul[29:0];
          state_r <= S_FIN2;
        end
        S_FIN2: begin
          tsprod_r <= 48'(off_r) * 48'(step_r);
          tcol_r   <= mirror ? 5'(7'(TEX_SIZE - 1) - t7) : t7[4:0];
          state_r  <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_col_r   <= col_r;
            out_hit_r   <= hit_r;
            if (hit_r) begin
              out_side_r  <= side_r;
              out_dist_r  <= d_r;
              out_ds_r    <= ds_r;
              out_de_r    <= de_r;
              out_tcol_r  <= tcol_r;
              out_step_r  <= step_r;
              out_ts_r    <= (tsprod_r > 48'(START_MAX)) ? $signed({1'b0, START_MAX}) :
                             $signed({1'b0, tsprod_r[20:0]});
              out_shade_r <= (l_r == '0) ? 4'd0 : shade_of(d_r[23:16]);
            end else begin
              out_side_r  <= 1'b0;
              out_dist_r  <= '0;
              out_ds_r    <= '0;
              out_de_r    <= '0;
              out_tcol_r  <= '0;
              out_step_r  <= '0;
              out_ts_r    <= '0;
              out_shade_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_column_out    = out_col_r;
  assign out_hit           = out_hit_r;
  assign out_side          = out_side_r;
  assign out_wall_distance = out_dist_r;
  assign out_draw_start    = out_ds_r;
  assign out_draw_end      = out_de_r;
  assign out_tex_column    = out_tcol_r;
  assign out_tex_step      = out_step_r;
  assign out_tex_start     = out_ts_r;
  assign out_shade         = out_shade_r;

  // The walk never runs past its step limit.
  a_step_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> stepc_r <= SCW'(STEPS))
    else $error("walk step count beyond limit");

  // The divider is only started when idle.
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  // The map is only written while no walk can read it.
  a_map_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE))
    else $error("map write during a cast");

  // A miss reports nothing but the column; a hit has an ordered span.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> (out_wall_distance == 24'd0) && (out_shade == 4'd0))
    else $error("miss result carries wall data");

  a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_draw_start <= out_draw_end)
    else $error("wall span out of order");

endmodule

FILE: sv/rcd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module rcd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/rcd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on rcd_pkg for the status struct.
module rcd_div import rcd_pkg::*; #(
  parameter int NW = 38,
  parameter int DW = 27
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output div_stat_t     stat
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] acc_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // Shift the next dividend bit into the partial remainder and try the subtract.
  assign trial = {rem_r, acc_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  // Iteration control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend register fills with quotient bits from the right.
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
      acc_r <= {acc_r[NW-2:0], ge};
    end
  end

  assign quo         = acc_r;
  assign stat.busy   = busy_r;
  assign stat.done   = done_r;
  assign stat.rem_nz = rem_r != '0;

endmodule

FILE: test/raycast_column_dda_tb.sv
// Self-checking bench for the grid raycaster: map writes and column casts.
// Depends on rcd_pkg and the raycast_column_dda top level only.
module raycast_column_dda_tb;
  import rcd_pkg::*;

  localparam int MAP_N = 32;
  localparam int TEX_N = 32;
  localparam int LIMIT_CYCLES = 3000000;

  typedef struct packed {
    logic       op;
    logic [9:0] column;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic [3:0] cell_value;
  } request_t;

  typedef struct packed {
    logic [9:0]  column_out;
    logic        hit;
    logic        side;
    logic [23:0] wall_distance;
    logic [9:0]  draw_start;
    logic [9:0]  draw_end;
    logic [4:0]  tex_column;
    logic [21:0] tex_step;
    logic [21:0] tex_start;
    logic [3:0]  shade;
  } column_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_stall, in_op;
  logic [9:0] in_column;
  logic [4:0] in_cell_x, in_cell_y;
  logic [3:0] in_cell_value;
  logic out_valid, out_stall;
  logic [9:0] out_column_out, out_draw_start, out_draw_end;
  logic out_hit, out_side;
  logic [23:0] out_wall_distance;
  logic [4:0] out_tex_column;
  logic [21:0] out_tex_step;
  logic signed [21:0] out_tex_start;
  logic [3:0] out_shade;

  raycast_column_dda u_top (.*);

  // Predictor state: camera registers and the map.
  logic [20:0] cam_reg [8];
  logic [3:0]  grid [MAP_N*MAP_N];

  request_t pending_q [$];
  column_t  columns_q [$];
  int errors, cycles, casts_seen, hits_seen, walls_seen;
  bit hold_off;
  int hold_count;
  bit in_taken;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint sx16(logic [20:0] v);
    return longint'($signed(v[15:0]));
  endfunction

  // Predict the result of one cast from the camera registers and the map.
  function automatic column_t trace_column(logic [9:0] col);
    column_t r;
    longint w, h, rx, ry, arx, ary, mx, my, stx, sty, ax, ay, last_a, d, l, ds, de;
    longint stp, ts, wc, t, den;
    bit hit_f, side_f;
    r = '0;
    r.column_out = col;
    w = longint'(cam_reg[6]); if (w < 1) w = 1;
    h = longint'(cam_reg[7]); if (h < 4) h = 4; if (h > 1024) h = 1024;
    rx = sx16(cam_reg[2]) + fdiv(sx16(cam_reg[4]) * (2 * longint'(col) - w), w);
    ry = sx16(cam_reg[3]) + fdiv(sx16(cam_reg[5]) * (2 * longint'(col) - w), w);
    arx = rx < 0 ? -rx : rx;
    ary = ry < 0 ? -ry : ry;
    mx = longint'(cam_reg[0][20:16]);
    my = longint'(cam_reg[1][20:16]);
    stx = rx < 0 ? -1 : 1;
    sty = ry < 0 ? -1 : 1;
    ax = rx < 0 ? longint'(cam_reg[0][15:0]) : 65536 - longint'(cam_reg[0][15:0]);
    ay = ry < 0 ? longint'(cam_reg[1][15:0]) : 65536 - longint'(cam_reg[1][15:0]);
    hit_f = 0; side_f = 0; last_a = 0;
    for (int i = 0; i < 2 * MAP_N; i++) begin
      if (ax * ary < ay * arx) begin
        last_a = ax; ax += 65536; mx += stx; side_f = 0;
      end else begin
        last_a = ay; ay += 65536; my += sty; side_f = 1;
      end
      if (mx < 0 || mx >= MAP_N || my < 0 || my >= MAP_N || grid[mx*MAP_N+my] != 0) begin
        hit_f = 1;
        break;
      end
    end
    if (!hit_f) return r;
    den = side_f ? ary : arx;
    if (den == 0) d = 24'hFFFFFF;
    else begin
      d = last_a * 16384 / den;
      if (d > 24'hFFFFFF) d = 24'hFFFFFF;
    end
    l = (h * 65536) / (d == 0 ? 1 : d);
    l = l & ~longint'(1);
    ds = h / 2 - l / 2; if (ds < 1) ds = 1;
    de = h / 2 + l / 2; if (de > h - 2) de = h - 2;
    if (l == 0) stp = 4194303;
    else begin
      stp = longint'(TEX_N) * 65536 / l;
      if (stp > 4194303) stp = 4194303;
    end
    ts = l == 0 ? 0 : (ds - h / 2 + l / 2) * stp;
    if (ts > 2097151) ts = 2097151;
    if (!side_f) wc = longint'(cam_reg[1]) + fdiv(d * ry, 16384);
    else wc = longint'(cam_reg[0]) + fdiv(d * rx, 16384);
    t = ((wc & 64'hFFFF) * TEX_N) >> 16;
    if ((!side_f && rx > 0) || (side_f && ry < 0)) t = TEX_N - t - 1;
    r.hit = 1;
    r.side = side_f;
    r.wall_distance = d[23:0];
    r.draw_start = ds[9:0];
    r.draw_end = de[9:0];
    r.tex_column = t[4:0];
    r.tex_step = stp[21:0];
    r.tex_start = ts[21:0];
    r.shade = l == 0 ? 4'd0 : 4'((23 - (d >> 16) % 23) / 2);
    return r;
  endfunction

  // Apply one accepted request to the predictor.
  task automatic predict_request(request_t q);
    if (q.op == OP_WRITE) begin
      grid[int'(q.cell_x)*MAP_N + int'(q.cell_y)] = q.cell_value;
    end else begin
      columns_q.push_back(trace_column(q.column));
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // Driver: presents queued requests at the falling edge.
  int drv_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (in_taken) begin
      // The request went in at the last rising edge.
      void'(pending_q.pop_front());
      if (drv_gap == 0) drv_gap = gap_len();
      if (pending_q.size() > 0 && drv_gap == 0) begin
        in_op <= pending_q[0].op;
        in_column <= pending_q[0].column;
        in_cell_x <= pending_q[0].cell_x;
        in_cell_y <= pending_q[0].cell_y;
        in_cell_value <= pending_q[0].cell_value;
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
    end else if (!in_valid) begin
      if (drv_gap > 0) drv_gap--;
      else if (pending_q.size() > 0) begin
        in_op <= pending_q[0].op;
        in_column <= pending_q[0].column;
        in_cell_x <= pending_q[0].cell_x;
        in_cell_y <= pending_q[0].cell_y;
        in_cell_value <= pending_q[0].cell_value;
        in_valid <= 1;
        drv_gap = gap_len();
      end
    end
  end

  // Predict at the rising edge where the request is accepted.
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken)
      predict_request(pending_q[0]);
  end

  // Receiver stall: random gaps, plus a long hold-off when asked.
  int rx_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else if (hold_off) begin
      out_stall <= 1;
      if (hold_count > 0) hold_count--;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_stall <= 1;
    end else begin
      out_stall <= 0;
      if ($urandom_range(9) == 0) rx_gap = gap_len();
    end
  end

  // Monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    column_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (columns_q.size() == 0) begin
        report_mismatch("unexpected result, column", out_column_out, -1);
      end else begin
        e = columns_q.pop_front();
        casts_seen++;
        if (out_hit) hits_seen++;
        if (out_column_out !== e.column_out) report_mismatch("column_out", out_column_out, e.column_out);
        if (out_hit !== e.hit) report_mismatch("hit", out_hit, e.hit);
        if (out_side !== e.side) report_mismatch("side", out_side, e.side);
        if (out_wall_distance !== e.wall_distance)
          report_mismatch("wall_distance", out_wall_distance, e.wall_distance);
        if (out_draw_start !== e.draw_start) report_mismatch("draw_start", out_draw_start, e.draw_start);
        if (out_draw_end !== e.draw_end) report_mismatch("draw_end", out_draw_end, e.draw_end);
        if (out_tex_column !== e.tex_column) report_mismatch("tex_column", out_tex_column, e.tex_column);
        if (out_tex_step !== e.tex_step) report_mismatch("tex_step", out_tex_step, e.tex_step);
        if (out_tex_start !== e.tex_start) report_mismatch("tex_start", out_tex_start, e.tex_start);
        if (out_shade !== e.shade) report_mismatch("shade", out_shade, e.shade);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout with %0d results outstanding", columns_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_POS_X, CFG_POS_Y: cam_reg[idx] = 21'(val);
      CFG_SCREEN_W, CFG_SCREEN_H: cam_reg[idx] = {10'd0, val[10:0]};
      default: cam_reg[idx] = {5'd0, val[15:0]};
    endcase
  endtask

  task automatic queue_write(int x, int y, int v);
    request_t q;
    q = '0;
    q.op = OP_WRITE; q.cell_x = 5'(x); q.cell_y = 5'(y); q.cell_value = 4'(v);
    q.column = 10'($urandom_range(1023));
    pending_q.push_back(q);
  endtask

  task automatic queue_cast(int c);
    request_t q;
    q = '0;
    q.op = OP_CAST; q.column = 10'(c);
    q.cell_x = 5'($urandom); q.cell_y = 5'($urandom); q.cell_value = 4'($urandom);
    pending_q.push_back(q);
  endtask

  // Wait until every request is in and every result is out, then settle.
  task automatic drain();
    while (pending_q.size() > 0 || columns_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Random camera: position inside the map, vectors of any sign.
  task automatic random_camera(bit extreme);
    if (extreme) begin
      write_reg(CFG_POS_X, $urandom_range(1) ? 32'h1FFFFF : 32'd0);
      write_reg(CFG_POS_Y, $urandom_range(1) ? 32'h1FFFFF : 32'd0);
      write_reg(CFG_DIR_X, $urandom_range(1) ? 32'h8000 : 32'h7FFF);
      write_reg(CFG_DIR_Y, $urandom_range(1) ? 32'h8000 : 32'h7FFF);
      write_reg(CFG_PLANE_X, $urandom);
      write_reg(CFG_PLANE_Y, $urandom);
      write_reg(CFG_SCREEN_W, $urandom_range(1) ? 32'd2 : 32'd1024);
      write_reg(CFG_SCREEN_H, $urandom_range(1) ? 32'd4 : 32'd1024);
    end else begin
      write_reg(CFG_POS_X, $urandom_range(32 * 65536 - 1));
      write_reg(CFG_POS_Y, $urandom_range(32 * 65536 - 1));
      write_reg(CFG_DIR_X, $urandom_range(65535));
      write_reg(CFG_DIR_Y, $urandom_range(65535));
      write_reg(CFG_PLANE_X, $urandom_range(3) == 0 ? 0 : $urandom_range(65535));
      write_reg(CFG_PLANE_Y, $urandom_range(65535));
      write_reg(CFG_SCREEN_W, $urandom_range(1024, 2));
      write_reg(CFG_SCREEN_H, $urandom_range(1024, 4));
    end
  endtask

  initial begin
    int batch, w;
    rst_n = 0; cfg_we = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0; in_op = 0; in_column = 0; in_cell_x = 0; in_cell_y = 0;
    in_cell_value = 0; out_stall = 0;
    errors = 0; cycles = 0; casts_seen = 0; hits_seen = 0; walls_seen = 0;
    hold_off = 0; hold_count = 0; drv_gap = 0; rx_gap = 0;
    cam_reg[0] = 21'd1441792; cam_reg[1] = 21'd786432; cam_reg[2] = 21'h0C000;
    cam_reg[3] = 21'd0; cam_reg[4] = 21'd0; cam_reg[5] = 21'd10813; cam_reg[6] = 21'd160;
    cam_reg[7] = 21'd96;
    foreach (grid[i]) grid[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: empty map under default camera, edge columns and cells.
    queue_cast(0); queue_cast(80); queue_cast(159); queue_cast(1023);
    queue_write(0, 0, 15); queue_write(31, 31, 1); queue_write(20, 12, 4);
    queue_write(21, 12, 9); queue_write(21, 11, 0); queue_write(10, 20, 8);
    queue_cast(80); queue_cast(0); queue_cast(159); queue_cast(512);
    drain();
    // Null ray, in both components, then in x only.
    write_reg(CFG_DIR_X, 0); write_reg(CFG_PLANE_Y, 0);
    queue_cast(5);
    drain();
    write_reg(CFG_DIR_Y, 32'h4000);
    queue_cast(7);
    drain();
    // Extreme registers, including a camera in the map corners.
    for (int k = 0; k < 4; k++) begin
      random_camera(1);
      queue_cast($urandom_range(1023)); queue_cast(0); queue_cast(1023);
      drain();
    end

    // Random phases: wall writes interleaved with casts under each camera.
    for (batch = 0; batch < 30; batch++) begin
      random_camera(batch % 10 == 9);
      for (int k = 0; k < 60; k++) begin
        if ($urandom_range(99) < 25) begin
          w = $urandom_range(3) == 0 ? 0 : $urandom_range(15, 1);
          queue_write($urandom_range(31), $urandom_range(31), w);
          walls_seen++;
        end else begin
          queue_cast($urandom_range(3) == 0 ? $urandom_range(1023)
                                            : $urandom_range(cam_reg[6] - 1));
        end
      end
      // Once, hold the receiver so the block backs up its input.
      if (batch == 5) begin
        hold_count = 400;
        hold_off = 1;
        while (hold_count > 0) @(posedge clk);
        hold_off = 0;
      end
      drain();
    end

    $display("covered %0d casts (%0d hits) and %0d map writes over 34 camera settings",
             casts_seen, hits_seen, walls_seen + 6);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d field mismatches", errors);
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
